@@ hdl/tof_distance_ema_wall_detector_unit_macros.svh @@
// Assertion macros shared by the checker of the range filter block.
`ifndef TOF_DISTANCE_EMA_WALL_DETECTOR_UNIT_MACROS_SVH
`define TOF_DISTANCE_EMA_WALL_DETECTOR_UNIT_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define TDEU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tdeu assertion failed");

// Implication in the next cycle, checked outside reset.
`define TDEU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tdeu assertion failed");

// Implication in the next cycle, checked also while reset is applied.
`define TDEU_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tdeu assertion failed");

`endif

@@ hdl/tdeu_pkg.sv @@
// Types, constants and helper functions of the range filter block.
package tdeu_pkg;

    localparam int CHANNELS  = 5;
    localparam int CH_W      = 3;
    localparam int DIST_W    = 13;
    localparam int RAW_W     = 16;
    localparam int ERR_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 48;

    localparam logic [DIST_W-1:0] INVALID_MM   = 13'd8190;
    localparam logic [RAW_W-1:0]  RAW_LIMIT_MM = 16'd8000;
    localparam logic signed [ERR_W:0] ERR_MAX  = 15'sd8190;

    // floor(x / 10) for x below 2^18 equals (x * 52429) >> 19.
    localparam int SUM_W   = 17;
    localparam int RECIP_W = 16;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic [CH_W-1:0] CH_FRONT       = 3'd0;
    localparam logic [CH_W-1:0] CH_FRONT_LEFT  = 3'd1;
    localparam logic [CH_W-1:0] CH_FRONT_RIGHT = 3'd2;
    localparam logic [CH_W-1:0] CH_LEFT        = 3'd3;
    localparam logic [CH_W-1:0] CH_RIGHT       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LIM = 3'd3;

    localparam logic [DIST_W-1:0] SIDE_THR_RST  = 13'd100;
    localparam logic [DIST_W-1:0] FRONT_THR_RST = 13'd120;
    localparam logic [DIST_W-1:0] TARGET_RST    = 13'd30;
    localparam logic [DIST_W-1:0] ALIGN_LIM_RST = 13'd150;

    typedef logic [DIST_W-1:0] dist_arr_t [CHANNELS];

    typedef struct packed {
        logic [DIST_W-1:0] side_thr;
        logic [DIST_W-1:0] front_thr;
        logic [DIST_W-1:0] target;
        logic [DIST_W-1:0] align_lim;
    } cfg_t;

    typedef struct packed {
        logic                    wall_left;
        logic                    wall_right;
        logic                    wall_front;
        logic signed [ERR_W-1:0] centering_error;
        logic signed [ERR_W-1:0] alignment_error;
    } wall_res_t;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] v);
        logic signed [ERR_W:0] r;
        begin
            r = v;
            if (v > ERR_MAX) begin
                r = ERR_MAX;
            end else if (v < -ERR_MAX) begin
                r = -ERR_MAX;
            end
            return r[ERR_W-1:0];
        end
    endfunction

endpackage

@@ hdl/tdeu_ema.sv @@
// Per-channel filtered distance store with the moving-average update.
module tdeu_ema (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           upd_en,
    input  logic [tdeu_pkg::CH_W-1:0]      upd_ch,
    input  logic [tdeu_pkg::RAW_W-1:0]     upd_raw,
    output tdeu_pkg::dist_arr_t            dist_view,
    output logic [tdeu_pkg::DIST_W-1:0]    filt
);

    tdeu_pkg::dist_arr_t dist_reg;

    logic [tdeu_pkg::DIST_W-1:0]  old_dist;
    logic [tdeu_pkg::DIST_W-1:0]  new_dist;
    logic [tdeu_pkg::SUM_W-1:0]   wsum;
    logic [tdeu_pkg::SUM_W+tdeu_pkg::RECIP_W-1:0] prod;
    logic [tdeu_pkg::DIST_W-1:0]  quot;
    logic                         raw_ok;

    always_comb begin
        old_dist = tdeu_pkg::INVALID_MM;
        for (int i = 0; i < tdeu_pkg::CHANNELS; i++) begin
            if (upd_ch == tdeu_pkg::CH_W'(i)) begin
                old_dist = dist_reg[i];
            end
        end
    end

    // Weighted sum 7*old + 3*raw, then divide by ten via the reciprocal.
    assign raw_ok = upd_raw < tdeu_pkg::RAW_LIMIT_MM;
    assign wsum   = tdeu_pkg::SUM_W'(old_dist) * tdeu_pkg::SUM_W'(7)
                  + tdeu_pkg::SUM_W'(upd_raw[tdeu_pkg::DIST_W-1:0]) * tdeu_pkg::SUM_W'(3);
    assign prod   = wsum * tdeu_pkg::RECIP_TEN;
    assign quot   = prod[tdeu_pkg::RECIP_SHIFT +: tdeu_pkg::DIST_W];

    always_comb begin
        if (!raw_ok) begin
            new_dist = tdeu_pkg::INVALID_MM;
        end else if (old_dist == tdeu_pkg::INVALID_MM) begin
            new_dist = upd_raw[tdeu_pkg::DIST_W-1:0];
        end else begin
            new_dist = quot;
        end
    end

    always_comb begin
        filt = tdeu_pkg::INVALID_MM;
        for (int i = 0; i < tdeu_pkg::CHANNELS; i++) begin
            dist_view[i] = dist_reg[i];
            if (upd_ch == tdeu_pkg::CH_W'(i)) begin
                dist_view[i] = new_dist;
                filt         = new_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tdeu_pkg::CHANNELS; i++) begin
                dist_reg[i] <= tdeu_pkg::INVALID_MM;
            end
        end else if (upd_en) begin
            for (int i = 0; i < tdeu_pkg::CHANNELS; i++) begin
                dist_reg[i] <= dist_view[i];
            end
        end
    end

endmodule

@@ hdl/tdeu_wall.sv @@
// Wall flags and signed centering and alignment errors from the distances.
module tdeu_wall (
    input  tdeu_pkg::dist_arr_t  dist_in,
    input  tdeu_pkg::cfg_t       cfg,
    output tdeu_pkg::wall_res_t  res
);

    logic [tdeu_pkg::DIST_W-1:0] d_l;
    logic [tdeu_pkg::DIST_W-1:0] d_r;
    logic [tdeu_pkg::DIST_W-1:0] d_f;
    logic [tdeu_pkg::DIST_W-1:0] d_fl;
    logic [tdeu_pkg::DIST_W-1:0] d_fr;
    logic signed [tdeu_pkg::ERR_W:0] s_l;
    logic signed [tdeu_pkg::ERR_W:0] s_r;
    logic signed [tdeu_pkg::ERR_W:0] s_fl;
    logic signed [tdeu_pkg::ERR_W:0] s_fr;
    logic signed [tdeu_pkg::ERR_W:0] s_tgt;
    logic signed [tdeu_pkg::ERR_W:0] c_diff;
    logic wl;
    logic wr;

    assign d_f  = dist_in[tdeu_pkg::CH_FRONT];
    assign d_fl = dist_in[tdeu_pkg::CH_FRONT_LEFT];
    assign d_fr = dist_in[tdeu_pkg::CH_FRONT_RIGHT];
    assign d_l  = dist_in[tdeu_pkg::CH_LEFT];
    assign d_r  = dist_in[tdeu_pkg::CH_RIGHT];

    assign s_l   = $signed({2'b00, d_l});
    assign s_r   = $signed({2'b00, d_r});
    assign s_fl  = $signed({2'b00, d_fl});
    assign s_fr  = $signed({2'b00, d_fr});
    assign s_tgt = $signed({2'b00, cfg.target});

    assign wl = d_l < cfg.side_thr;
    assign wr = d_r < cfg.side_thr;

    always_comb begin
        priority if (wl && wr) begin
            c_diff = s_r - s_l;
        end else if (wl) begin
            c_diff = s_tgt - s_l;
        end else if (wr) begin
            c_diff = s_r - s_tgt;
        end else begin
            c_diff = '0;
        end
    end

    always_comb begin
        res.wall_left       = wl;
        res.wall_right      = wr;
        res.wall_front      = d_f < cfg.front_thr;
        res.centering_error = tdeu_pkg::sat_err(c_diff);
        if (d_fl < cfg.align_lim && d_fr < cfg.align_lim) begin
            res.alignment_error = tdeu_pkg::sat_err(s_fr - s_fl);
        end else begin
            res.alignment_error = '0;
        end
    end

endmodule

@@ hdl/tof_distance_ema_wall_detector_unit.sv @@
// Top level of the five-channel range filter with wall and alignment detection.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tuser: channel; s_tdata: raw_mm
// m_       out  m_tvalid/m_tready  m_tuser: channel_out; m_tdata: filtered and flags
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (low 13 bits used)
//
// One item per cycle is sustained while m_tready stays high; each item passes
// through the input register and then sits in the result register.
// The filter update, the divide-by-ten multiply and the wall compares all
// run in the single step from the input register to the result register.
// Reset (aresetn low, synchronous) sets every channel to the invalid mark
// and loads the default thresholds. A stall on m_ holds the result register
// and backs up through the input register to s_tready; cfg_ready stays high.
module tof_distance_ema_wall_detector_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tdeu_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] raw_mm
    input  logic [tdeu_pkg::CH_W-1:0]         s_tuser,   // [2:0] channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [12:0] filtered_mm, [13] wall_left, [14] wall_right, [15] wall_front,
    // [29:16] centering_error, [43:30] alignment_error, [47:44] zero
    output logic [tdeu_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [tdeu_pkg::CH_W-1:0]         m_tuser,   // [2:0] channel_out
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdeu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tdeu_pkg::CFG_DAT_W-1:0]    cfg_data
);

    tdeu_pkg::cfg_t cfg_reg;

    logic                           in_valid_reg;
    logic [tdeu_pkg::CH_W-1:0]      in_ch_reg;
    logic [tdeu_pkg::RAW_W-1:0]     in_raw_reg;
    logic                           out_valid_reg;
    logic [tdeu_pkg::CH_W-1:0]      out_ch_reg;
    logic [tdeu_pkg::DIST_W-1:0]    out_filt_reg;
    tdeu_pkg::wall_res_t            out_res_reg;

    logic                           advance;
    tdeu_pkg::dist_arr_t            dist_view;
    logic [tdeu_pkg::DIST_W-1:0]    filt;
    tdeu_pkg::wall_res_t            wall_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.side_thr  <= tdeu_pkg::SIDE_THR_RST;
            cfg_reg.front_thr <= tdeu_pkg::FRONT_THR_RST;
            cfg_reg.target    <= tdeu_pkg::TARGET_RST;
            cfg_reg.align_lim <= tdeu_pkg::ALIGN_LIM_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tdeu_pkg::CFG_SIDE_THR:  cfg_reg.side_thr  <= cfg_data[tdeu_pkg::DIST_W-1:0];
                tdeu_pkg::CFG_FRONT_THR: cfg_reg.front_thr <= cfg_data[tdeu_pkg::DIST_W-1:0];
                tdeu_pkg::CFG_TARGET:    cfg_reg.target    <= cfg_data[tdeu_pkg::DIST_W-1:0];
                tdeu_pkg::CFG_ALIGN_LIM: cfg_reg.align_lim <= cfg_data[tdeu_pkg::DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The item in the input register moves on whenever the result register
    // is empty or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tuser;
            in_raw_reg <= s_tdata;
        end
    end

    tdeu_ema u_ema (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (advance),
        .upd_ch    (in_ch_reg),
        .upd_raw   (in_raw_reg),
        .dist_view (dist_view),
        .filt      (filt)
    );

    tdeu_wall u_wall (
        .dist_in (dist_view),
        .cfg     (cfg_reg),
        .res     (wall_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ch_reg   <= in_ch_reg;
            out_filt_reg <= filt;
            out_res_reg  <= wall_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.alignment_error,
                       out_res_reg.centering_error,
                       out_res_reg.wall_front,
                       out_res_reg.wall_right,
                       out_res_reg.wall_left,
                       out_filt_reg};

endmodule

@@ hdl/tdeu_checker.sv @@
// Port-level checker of the range filter block and its bind to the top level.
`include "tof_distance_ema_wall_detector_unit_macros.svh"

module tdeu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tdeu_pkg::M_DATA_W-1:0]     m_tdata,
    input logic [tdeu_pkg::CH_W-1:0]         m_tuser
);

    // A result waiting on the output side keeps its value.
    `TDEU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the result register.
    `TDEU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // A channel number beyond the five sensors reports the invalid mark.
    `TDEU_ASSERT_SAME(a_bad_ch_invalid, aclk, aresetn, m_tvalid && (m_tuser > tdeu_pkg::CH_RIGHT), m_tdata[12:0] == tdeu_pkg::INVALID_MM)

    // With no side wall there is nothing to center on.
    `TDEU_ASSERT_SAME(a_no_wall_no_err, aclk, aresetn, m_tvalid && !m_tdata[13] && !m_tdata[14], m_tdata[29:16] == 14'd0)

    // Both errors stay inside the saturation range.
    `TDEU_ASSERT_SAME(a_err_range, aclk, aresetn, m_tvalid, (m_tdata[29:16] != 14'h1FFF) && (m_tdata[29:16] != 14'h2000) && (m_tdata[29:16] != 14'h2001) && (m_tdata[43:30] != 14'h1FFF) && (m_tdata[43:30] != 14'h2000) && (m_tdata[43:30] != 14'h2001))

endmodule

bind tof_distance_ema_wall_detector_unit tdeu_checker u_tdeu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/tb_tof_distance_ema_wall_detector_unit.sv @@
// Self-checking testbench for the five-channel range filter with wall and alignment detection.
module tb_tof_distance_ema_wall_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tdeu_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 5;
    localparam int STALL_LIMIT     = 2000;
    localparam int LONG_HOLD       = 400;
    localparam int HOLD_AFTER      = 500;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 10;

    localparam logic [CH_W-1:0]      CH_SPARE_LO = 3'd5;
    localparam logic [CH_W-1:0]      CH_SPARE_MID = 3'd6;
    localparam logic [CH_W-1:0]      CH_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic [DIST_W-1:0]       filtered;
        logic                    wall_left;
        logic                    wall_right;
        logic                    wall_front;
        logic signed [ERR_W-1:0] centering;
        logic signed [ERR_W-1:0] alignment;
    } range_result_t;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw;
        bit               typed;
        range_result_t    want;
    } sample_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_ALTERNATE, RX_MOSTLY} rx_mode_e;

    localparam range_result_t UNTYPED = '0;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [CH_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [CH_W-1:0]       m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    // Side information that travels with the item on the input channel.
    bit                    item_typed = 1'b0;
    range_result_t         item_want  = '0;

    dist_arr_t             dist_est;
    cfg_t                  cfg_est;
    range_result_t         pending_results[$];
    int                    mismatches     = 0;
    int                    accepted_items = 0;
    int                    burst_left     = 0;

    tof_distance_ema_wall_detector_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clamp_err_mm(input int v);
        if (v > int'(ERR_MAX)) return int'(ERR_MAX);
        if (v < -int'(ERR_MAX)) return -int'(ERR_MAX);
        return v;
    endfunction

    // Folds one sample into the channel estimates and works out the result it causes.
    function automatic range_result_t fold_sample(input logic [CH_W-1:0] ch,
                                                  input logic [RAW_W-1:0] raw);
        range_result_t res;
        int old_mm, f, fl, fr, l, r, cerr, aerr;
        res = '0;
        res.channel = ch;
        res.filtered = INVALID_MM;
        if (int'(ch) < CHANNELS) begin
            old_mm = int'(dist_est[ch]);
            if (raw < RAW_LIMIT_MM) begin
                if (old_mm == int'(INVALID_MM)) begin
                    dist_est[ch] = raw[DIST_W-1:0];
                end else begin
                    dist_est[ch] = DIST_W'((7 * old_mm + 3 * int'(raw)) / 10);
                end
            end else begin
                dist_est[ch] = INVALID_MM;
            end
            res.filtered = dist_est[ch];
        end
        f  = int'(dist_est[CH_FRONT]);
        fl = int'(dist_est[CH_FRONT_LEFT]);
        fr = int'(dist_est[CH_FRONT_RIGHT]);
        l  = int'(dist_est[CH_LEFT]);
        r  = int'(dist_est[CH_RIGHT]);
        res.wall_left  = l < int'(cfg_est.side_thr);
        res.wall_right = r < int'(cfg_est.side_thr);
        res.wall_front = f < int'(cfg_est.front_thr);
        cerr = 0;
        if (res.wall_left && res.wall_right) begin
            cerr = r - l;
        end else if (res.wall_left) begin
            cerr = int'(cfg_est.target) - l;
        end else if (res.wall_right) begin
            cerr = r - int'(cfg_est.target);
        end
        aerr = 0;
        if (fl < int'(cfg_est.align_lim) && fr < int'(cfg_est.align_lim)) begin
            aerr = clamp_err_mm(fr - fl);
        end
        res.centering = ERR_W'(clamp_err_mm(cerr));
        res.alignment = ERR_W'(aerr);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        range_result_t want_r, got_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_r.channel    = m_tuser;
                got_r.filtered   = m_tdata[12:0];
                got_r.wall_left  = m_tdata[13];
                got_r.wall_right = m_tdata[14];
                got_r.wall_front = m_tdata[15];
                got_r.centering  = m_tdata[29:16];
                got_r.alignment  = m_tdata[43:30];
                if (pending_results.size() == 0) begin
                    $error("result for channel %0d arrived with nothing expected", m_tuser);
                    mismatches++;
                end else begin
                    want_r = pending_results.pop_front();
                    check_field("channel_out", want_r.channel, got_r.channel);
                    check_field("filtered_mm", want_r.filtered, got_r.filtered);
                    check_field("wall_left", want_r.wall_left, got_r.wall_left);
                    check_field("wall_right", want_r.wall_right, got_r.wall_right);
                    check_field("wall_front", want_r.wall_front, got_r.wall_front);
                    check_field("centering_error", int'(want_r.centering),
                                int'(got_r.centering));
                    check_field("alignment_error", int'(want_r.alignment),
                                int'(got_r.alignment));
                    check_field("tdata_pad", 0, int'(m_tdata[47:44]));
                end
            end
            if (s_tvalid && s_tready) begin
                // The predictor always runs so the channel estimates stay in step.
                want_r = fold_sample(s_tuser, s_tdata[RAW_W-1:0]);
                pending_results.push_back(item_typed ? item_want : want_r);
                accepted_items++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Result side: changing stall patterns, plus one long hold that backs up the input.
    initial begin : receiver
        rx_mode_e mode;
        int mode_left, hold_left;
        bit hold_done;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted_items >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:      m_tready <= 1'b1;
                    RX_COIN:      m_tready <= 1'($urandom_range(0, 1));
                    RX_ALTERNATE: m_tready <= mode_left[0];
                    default:      m_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
                               input bit typed, input range_result_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid   <= 1'b1;
        s_tuser    <= ch;
        s_tdata    <= raw;
        item_typed <= typed;
        item_want  <= want;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        // Bits above the register width are don't-care and get random values.
        cfg_data  <= {3'($urandom), value};
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            CFG_SIDE_THR:  cfg_est.side_thr  = value;
            CFG_FRONT_THR: cfg_est.front_thr = value;
            CFG_TARGET:    cfg_est.target    = value;
            CFG_ALIGN_LIM: cfg_est.align_lim = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    initial begin : stimulus
        sample_row_t directed_rows[$];
        cfg_t next_cfg;
        logic [CH_W-1:0] ch;
        logic [RAW_W-1:0] raw;
        int pick;

        for (int i = 0; i < CHANNELS; i++) dist_est[i] = INVALID_MM;
        cfg_est = '{SIDE_THR_RST, FRONT_THR_RST, TARGET_RST, ALIGN_LIM_RST};

        // Typed rows are read straight off the behavior after reset.
        directed_rows.push_back('{CH_FRONT, 16'd8190, 1'b1,
            '{CH_FRONT, INVALID_MM, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0}});
        directed_rows.push_back('{CH_SPARE_LO, 16'd0, 1'b1,
            '{CH_SPARE_LO, INVALID_MM, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0}});
        directed_rows.push_back('{CH_SPARE_HI, 16'hFFFF, 1'b1,
            '{CH_SPARE_HI, INVALID_MM, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0}});
        directed_rows.push_back('{CH_LEFT, 16'd0, 1'b1,
            '{CH_LEFT, 13'd0, 1'b1, 1'b0, 1'b0, 14'sd30, 14'sd0}});
        directed_rows.push_back('{CH_RIGHT, 16'd0, 1'b1,
            '{CH_RIGHT, 13'd0, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0}});
        directed_rows.push_back('{CH_RIGHT, 16'd7999, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_RIGHT, RAW_LIMIT_MM, 1'b1,
            '{CH_RIGHT, INVALID_MM, 1'b1, 1'b0, 1'b0, 14'sd30, 14'sd0}});
        directed_rows.push_back('{CH_FRONT_LEFT, 16'd10, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT_RIGHT, 16'd140, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT, 16'd50, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT, 16'hFFFF, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT, 16'd8189, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT, 16'd0, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT, 16'd7999, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'h5555, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'hAAAA, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'd7999, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'd0, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT_LEFT, 16'h1555, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_FRONT_RIGHT, 16'h0AAA, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_SPARE_MID, 16'h1FFF, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'd8190, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_LEFT, 16'd40, 1'b0, UNTYPED});
        directed_rows.push_back('{CH_RIGHT, 16'd70, 1'b0, UNTYPED});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].channel, directed_rows[i].raw,
                        directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle(SETTLE_CYCLES);
            case (p)
                0: next_cfg = '{13'd0, 13'd0, 13'd0, 13'd0};
                1: next_cfg = '{INVALID_MM, INVALID_MM, INVALID_MM, INVALID_MM};
                2: next_cfg = '{SIDE_THR_RST, FRONT_THR_RST, TARGET_RST, ALIGN_LIM_RST};
                3: next_cfg = '{13'($urandom_range(0, 8190)), 13'($urandom_range(0, 8190)),
                                13'($urandom_range(0, 8190)), 13'($urandom_range(0, 8190))};
                default: next_cfg = '{13'($urandom_range(0, 400)), 13'($urandom_range(0, 400)),
                                       13'($urandom_range(0, 8190)),
                                       13'($urandom_range(0, 400))};
            endcase
            // A write to an unused index must leave every register alone.
            if (p == 2) cfg_put(CFG_SPARE, 13'($urandom));
            cfg_put(CFG_SIDE_THR, next_cfg.side_thr);
            cfg_put(CFG_FRONT_THR, next_cfg.front_thr);
            cfg_put(CFG_TARGET, next_cfg.target);
            cfg_put(CFG_ALIGN_LIM, next_cfg.align_lim);
            @(negedge aclk);
            cfg_valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                ch = (pick < 5) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
                pick = $urandom_range(0, 99);
                // Mostly short ranges, so the averages settle near the thresholds.
                if (pick < 55) begin
                    raw = 16'($urandom_range(0, 400));
                end else if (pick < 75) begin
                    raw = 16'($urandom_range(0, 7999));
                end else if (pick < 85) begin
                    raw = 16'($urandom_range(8000, 65535));
                end else if (pick < 92) begin
                    case ($urandom_range(0, 2))
                        0:       raw = 16'(INVALID_MM);
                        1:       raw = RAW_LIMIT_MM;
                        default: raw = RAW_LIMIT_MM - 16'd1;
                    endcase
                end else begin
                    raw = 16'($urandom_range(0, 65535));
                end
                send_sample(ch, raw, 1'b0, UNTYPED);
            end
        end

        wait_idle(END_CYCLES);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
